>>> rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the particle pool: slot record, result
// word, divider handshake and register map.
// ----------------------------------------------------------------------------
package ppu_pkg;

	localparam int SLOTS = 32;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_OUT_W = 6;

	localparam int POS_W = 32;
	localparam int LIFE_W = 16;
	localparam int TINT_W = 16;
	localparam int AGE_W = 17;
	localparam int FADE_W = 5;
	localparam int GRAV_W = 22;

	// Request operations
	localparam logic FN_CREATE = 1'b0;
	localparam logic FN_TICK = 1'b1;

	// Register map
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int IDX_W = ADDR_W - 2;
	localparam logic [IDX_W-1:0] REG_GRAVITY = '0;
	localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(256);

	// Alpha arithmetic
	localparam logic [FADE_W-1:0] ALPHA_FULL = FADE_W'(31);
	localparam int DVD_W = AGE_W + 5;
	// age never exceeds life + 1, so age*30/life stays below 64.
	localparam int Q_W = 6;
	localparam int STEP_W = $clog2(Q_W);

	typedef enum logic [1:0] {
		K_CREATED = 2'd0,
		K_FULL = 2'd1,
		K_RECORD = 2'd2,
		K_EMPTY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [POS_W-1:0] vx;
		logic [POS_W-1:0] vy;
		logic [POS_W-1:0] vz;
		logic [LIFE_W-1:0] life;
		logic [TINT_W-1:0] tint;
		logic [AGE_W-1:0] age;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef struct packed {
		kind_t kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		logic [FADE_W-1:0] fade;
		logic [TINT_W-1:0] tint;
		logic last;
	} rsp_word_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [LIFE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/ppu_ram.sv
// ----------------------------------------------------------------------------
// ppu_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ppu_div.sv
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider for the alpha fade, one quotient bit per cycle.
// The quotient is known to fit in Q_W bits, so only Q_W steps are run.
// ----------------------------------------------------------------------------
module ppu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ppu_pkg::div_req_t req,
	output ppu_pkg::div_rsp_t rsp
);

	logic [ppu_pkg::DVD_W-1:0] rem_q;
	logic [ppu_pkg::LIFE_W-1:0] dsr_q;
	logic [ppu_pkg::STEP_W-1:0] step_q;
	logic [ppu_pkg::Q_W-1:0] quot_q;
	logic busy_q;
	logic done_q;
	logic [ppu_pkg::DVD_W-1:0] trial;
	logic fits;

	assign trial = ppu_pkg::DVD_W'(dsr_q) << step_q;
	assign fits = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsr_q <= req.divisor;
			step_q <= ppu_pkg::STEP_W'(ppu_pkg::Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
			end
			quot_q <= {quot_q[ppu_pkg::Q_W-2:0], fits};
			step_q <= step_q - 1'b1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> rtl/ppu_cfg.sv
// ----------------------------------------------------------------------------
// ppu_cfg
// Configuration register file on the APB-style port. Holds the gravity
// constant and provides gravity/4 truncated toward zero.
// ----------------------------------------------------------------------------
module ppu_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppu_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppu_pkg::DATA_W-1:0]   pwdata,
	output logic [ppu_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [ppu_pkg::POS_W-1:0]    grav_quarter
);

	logic [ppu_pkg::GRAV_W-1:0] gravity_q;
	logic [ppu_pkg::IDX_W-1:0] reg_idx;
	logic [ppu_pkg::POS_W-1:0] grav_ext;
	logic [ppu_pkg::POS_W-1:0] grav_shr;
	logic round_up;

	assign reg_idx = paddr[ppu_pkg::ADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= ppu_pkg::GRAVITY_RST;
		end else if (psel && penable && pwrite && (reg_idx == ppu_pkg::REG_GRAVITY)) begin
			gravity_q <= pwdata[ppu_pkg::GRAV_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			ppu_pkg::REG_GRAVITY: prdata = ppu_pkg::DATA_W'($signed(gravity_q));
			default:              prdata = '0;
		endcase
	end

	// An arithmetic shift rounds toward minus infinity; negative values with
	// a nonzero remainder are bumped back toward zero.
	assign grav_ext = ppu_pkg::POS_W'($signed(gravity_q));
	assign grav_shr = $unsigned($signed(grav_ext) >>> 2);
	assign round_up = gravity_q[ppu_pkg::GRAV_W-1] && (gravity_q[1:0] != 2'b00);
	assign grav_quarter = grav_shr + ppu_pkg::POS_W'(round_up);

endmodule

>>> rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update
// Fixed pool of particle slots held in one slot memory. Creates claim the
// lowest free slot; a tick walks all live slots and reports each survivor.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+---------------------------------
//  req      | in        | req_valid/req_stall| func, position, velocity, life, tint
//  rsp      | out       | rsp_valid/rsp_stall| kind, slot, position, fade, tint, last
//  apb      | in        | psel/penable       | gravity register at offset 0
//
// A create is accepted and then claims its slot in S_CREATE. A tick is
// accepted, visits every slot, running memory read, update, the six-step
// fade divider and write-back (S_SCAN, S_CALC, S_DIV, S_WRITE) on each
// live slot, and closes in S_FLUSH. A new word is taken only when the
// previous one is fully worked off. Reset empties the pool at once through
// per-slot live flags; the slot memory itself is never cleared. A stalled
// result output holds creates, the close and survivors that push a record.
// ----------------------------------------------------------------------------
module particle_pool_update (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            func,
	input  logic [ppu_pkg::POS_W-1:0]       pos_x,
	input  logic [ppu_pkg::POS_W-1:0]       pos_y,
	input  logic [ppu_pkg::POS_W-1:0]       pos_z,
	input  logic [ppu_pkg::POS_W-1:0]       vel_x,
	input  logic [ppu_pkg::POS_W-1:0]       vel_y,
	input  logic [ppu_pkg::POS_W-1:0]       vel_z,
	input  logic [ppu_pkg::LIFE_W-1:0]      lifetime,
	input  logic [ppu_pkg::TINT_W-1:0]      tint,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [1:0]                      kind,
	output logic [ppu_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [ppu_pkg::POS_W-1:0]       out_x,
	output logic [ppu_pkg::POS_W-1:0]       out_y,
	output logic [ppu_pkg::POS_W-1:0]       out_z,
	output logic [ppu_pkg::FADE_W-1:0]      fade,
	output logic [ppu_pkg::TINT_W-1:0]      out_tint,
	output logic                            last,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppu_pkg::ADDR_W-1:0]      paddr,
	input  logic [ppu_pkg::DATA_W-1:0]      pwdata,
	output logic [ppu_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CREATE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_CALC   = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_WRITE  = 7'b0100000,
		S_FLUSH  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [ppu_pkg::SLOTS-1:0] live_q;
	logic [ppu_pkg::SLOT_W-1:0] idx_q;
	ppu_pkg::slot_rec_t crt_q;
	ppu_pkg::slot_rec_t cur_q;
	ppu_pkg::rsp_word_t pend_q;
	logic pend_v_q;
	ppu_pkg::rsp_word_t rsp_q;
	logic rsp_valid_q;

	logic [ppu_pkg::POS_W-1:0] grav_quarter;
	ppu_pkg::slot_rec_t ram_rdata;
	ppu_pkg::slot_rec_t ram_wdata;
	logic [ppu_pkg::SLOT_W-1:0] ram_waddr;
	logic ram_we;
	ppu_pkg::div_req_t div_req;
	ppu_pkg::div_rsp_t div_rsp;

	logic [ppu_pkg::SLOT_W-1:0] free_idx;
	logic free_found;
	logic out_free;
	logic alive;
	logic create_go;
	logic write_go;
	logic flush_go;
	logic out_load;
	logic last_slot;
	logic [ppu_pkg::AGE_W-1:0] age_next;
	ppu_pkg::rsp_word_t rec_word;
	ppu_pkg::rsp_word_t out_d;

	ppu_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.grav_quarter (grav_quarter)
	);

	ppu_ram #(
		.WIDTH (ppu_pkg::REC_W),
		.DEPTH (ppu_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	ppu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		free_found = 1'b0;
		for (int i = ppu_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_idx = ppu_pkg::SLOT_W'(i);
				free_found = 1'b1;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign last_slot = (idx_q == ppu_pkg::SLOT_W'(ppu_pkg::SLOTS - 1));
	assign alive = (cur_q.age <= ppu_pkg::AGE_W'(cur_q.life));

	// A survivor replaces the pending record, which then leaves with last low.
	assign create_go = (state_q == S_CREATE) && out_free;
	assign write_go = (state_q == S_WRITE) && (!(alive && pend_v_q) || out_free);
	assign flush_go = (state_q == S_FLUSH) && out_free;
	assign out_load = create_go || flush_go || (write_go && alive && pend_v_q);

	// The read address follows idx_q, so in S_CALC the slot read in S_SCAN is
	// on ram_rdata. Write-back of a slot completes before the next read.
	assign age_next = ram_rdata.age + 1'b1;
	assign div_req.start = (state_q == S_CALC);
	assign div_req.dividend = ppu_pkg::DVD_W'({age_next, 5'b00000})
		- ppu_pkg::DVD_W'({age_next, 1'b0});
	assign div_req.divisor = ram_rdata.life;

	always_comb begin
		rec_word.kind = ppu_pkg::K_RECORD;
		rec_word.slot = ppu_pkg::SLOT_OUT_W'(idx_q);
		rec_word.x = cur_q.px;
		rec_word.y = cur_q.py;
		rec_word.z = cur_q.pz;
		rec_word.fade = ppu_pkg::ALPHA_FULL - div_rsp.quot[ppu_pkg::FADE_W-1:0];
		rec_word.tint = cur_q.tint;
		rec_word.last = 1'b0;
	end

	always_comb begin
		out_d = '0;
		out_d.last = 1'b1;
		unique case (state_q)
			S_CREATE: begin
				if (free_found) begin
					out_d.kind = ppu_pkg::K_CREATED;
					out_d.slot = ppu_pkg::SLOT_OUT_W'(free_idx);
				end else begin
					out_d.kind = ppu_pkg::K_FULL;
				end
			end
			S_FLUSH: begin
				if (pend_v_q) begin
					out_d = pend_q;
					out_d.last = 1'b1;
				end else begin
					out_d.kind = ppu_pkg::K_EMPTY;
				end
			end
			S_WRITE: begin
				out_d = pend_q;
				out_d.last = 1'b0;
			end
			default: out_d.kind = ppu_pkg::K_EMPTY;
		endcase
	end

	assign ram_we = (create_go && free_found) || write_go;
	assign ram_waddr = (state_q == S_CREATE) ? free_idx : idx_q;
	assign ram_wdata = (state_q == S_CREATE) ? crt_q : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			idx_q <= '0;
			pend_v_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q <= '0;
						pend_v_q <= 1'b0;
						state_q <= (func == ppu_pkg::FN_TICK) ? S_SCAN : S_CREATE;
					end
				end
				S_CREATE: begin
					if (create_go) begin
						if (free_found) begin
							live_q[free_idx] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (live_q[idx_q]) begin
						state_q <= S_CALC;
					end else if (last_slot) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CALC: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (write_go) begin
						live_q[idx_q] <= alive;
						if (alive) begin
							pend_v_q <= 1'b1;
						end
						if (last_slot) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FLUSH: begin
					if (flush_go) begin
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			crt_q.px <= pos_x;
			crt_q.py <= pos_y;
			crt_q.pz <= pos_z;
			crt_q.vx <= vel_x;
			crt_q.vy <= vel_y;
			crt_q.vz <= vel_z;
			crt_q.life <= (lifetime == '0) ? ppu_pkg::LIFE_W'(1) : lifetime;
			crt_q.tint <= tint;
			crt_q.age <= '0;
		end
		if (state_q == S_CALC) begin
			cur_q.px <= ram_rdata.px + ram_rdata.vx;
			cur_q.py <= ram_rdata.py + ram_rdata.vy - grav_quarter;
			cur_q.pz <= ram_rdata.pz + ram_rdata.vz;
			cur_q.vx <= ram_rdata.vx;
			cur_q.vy <= ram_rdata.vy;
			cur_q.vz <= ram_rdata.vz;
			cur_q.life <= ram_rdata.life;
			cur_q.tint <= ram_rdata.tint;
			cur_q.age <= age_next;
		end
		if (write_go && alive) begin
			pend_q <= rec_word;
		end
		if (out_load) begin
			rsp_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind = rsp_q.kind;
	assign slot = rsp_q.slot;
	assign out_x = rsp_q.x;
	assign out_y = rsp_q.y;
	assign out_z = rsp_q.z;
	assign fade = rsp_q.fade;
	assign out_tint = rsp_q.tint;
	assign last = rsp_q.last;

	// The slot memory is written only when a create lands or a live slot is written back, whether it retires or survives.
	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CREATE || state_q == S_WRITE))
		else $error("slot memory written outside create or write-back");

	// The divider is never restarted while a division is in flight.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// While waiting on the divider it must be working or just finished.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on an idle divider");

	// No record may be left pending between words.
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending record left over in idle");

	// A surviving slot stays live after its write-back.
	a_live_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(write_go && alive) |=> live_q[$past(idx_q)])
		else $error("surviving slot lost its live flag");

endmodule
